// ----- design/svang_pkg.sv -----
// svang_pkg: constants, control struct, opcode codes and arctangent table
// for the signed vector angle block. No dependencies.
package svang_pkg;

  localparam int CORDIC_STAGES_DEF = 16;
  localparam int COORD_BITS_DEF    = 16;

  localparam int ANG_W   = 17;
  localparam int NT_W    = 33;
  localparam int CB_W    = 15;
  localparam int Z_W     = 32;
  localparam int CFG_IDX_W = 2;

  localparam logic [14:0] GAIN_Q15 = 15'd19898;
  localparam logic signed [ANG_W-1:0] PI_Q13      = 17'sd25736;
  localparam logic signed [ANG_W-1:0] HALF_PI_Q13 = 17'sd12868;
  localparam logic signed [ANG_W-1:0] TWO_PI_Q13  = 17'sd51472;
  localparam logic signed [Z_W-1:0]   HALF_PI_Q29 = 32'sd843314857;

  localparam logic [CFG_IDX_W-1:0] REG_NULL_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COS_BAND       = 2'd1;

  typedef enum logic [1:0] {
    OP_SIGNED   = 2'd0,
    OP_POSITIVE = 2'd1,
    OP_SHORT    = 2'd2,
    OP_UNDEF    = 2'd3
  } op_t;

  typedef struct packed {
    logic       vld;
    logic [1:0] opcode;
    logic       d_pos;
    logic       dot_neg;
  } ctl_t;

  function automatic logic [Z_W-1:0] atan_q29(input int i);
    logic [Z_W-1:0] v;
    case (i)
      0:  v = 32'd421657428;
      1:  v = 32'd248918915;
      2:  v = 32'd131521918;
      3:  v = 32'd66762579;
      4:  v = 32'd33510843;
      5:  v = 32'd16771758;
      6:  v = 32'd8387925;
      7:  v = 32'd4194219;
      8:  v = 32'd2097141;
      9:  v = 32'd1048575;
      10: v = 32'd524288;
      11: v = 32'd262144;
      12: v = 32'd131072;
      13: v = 32'd65536;
      14: v = 32'd32768;
      15: v = 32'd16384;
      16: v = 32'd8192;
      17: v = 32'd4096;
      18: v = 32'd2048;
      19: v = 32'd1024;
      20: v = 32'd512;
      21: v = 32'd256;
      22: v = 32'd128;
      23: v = 32'd64;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ----- design/svang_if.sv -----
// svang_if: valid/ready channel interfaces for input items, results and
// configuration writes. Depends on svang_pkg.
interface svang_in_if #(parameter int COORD_BITS = svang_pkg::COORD_BITS_DEF);
  logic                         valid;
  logic                         ready;
  logic [1:0]                   opcode;
  logic signed [COORD_BITS-1:0] a_x;
  logic signed [COORD_BITS-1:0] a_y;
  logic signed [COORD_BITS-1:0] a_z;
  logic signed [COORD_BITS-1:0] b_x;
  logic signed [COORD_BITS-1:0] b_y;
  logic signed [COORD_BITS-1:0] b_z;
  logic signed [COORD_BITS-1:0] orient_x;
  logic signed [COORD_BITS-1:0] orient_y;
  logic signed [COORD_BITS-1:0] orient_z;
  modport source (output valid, opcode, a_x, a_y, a_z, b_x, b_y, b_z,
                  orient_x, orient_y, orient_z, input ready);
  modport sink (input valid, opcode, a_x, a_y, a_z, b_x, b_y, b_z,
                orient_x, orient_y, orient_z, output ready);
endinterface

interface svang_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [svang_pkg::ANG_W-1:0]    angle;
  logic                                  valid_res;
  modport source (output valid, angle, valid_res, input ready);
  modport sink (input valid, angle, valid_res, output ready);
endinterface

interface svang_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [svang_pkg::CFG_IDX_W-1:0]   index;
  logic [svang_pkg::NT_W-1:0]        data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- design/signed_vector_angle.sv -----
// Signed angle between two 3D integer vectors, one item per clock while the
// output is not stalled, fully pipelined. RW = 2*COORD_BITS+3 minus the
// pre-shift is the root width (35 root bits at the defaults): four stages
// form the products, cross and dot sums and squares, a chain of square root
// cells settles one root bit each, a chain of CORDIC cells does one rotation
// each, and three stages apply gain, null/band tests and the final angle.
// The whole pipe advances whenever the output register is empty or taken.
// Depends on svang_pkg, svang_if, svang_sqrt_cell and svang_cordic_cell.
module signed_vector_angle #(
  parameter int CORDIC_STAGES = svang_pkg::CORDIC_STAGES_DEF,
  parameter int COORD_BITS    = svang_pkg::COORD_BITS_DEF
) (
  input logic         clk,
  input logic         rst_n,
  svang_in_if.sink    in_ch,
  svang_out_if.source out_ch,
  svang_cfg_if.sink   cfg_ch
);
  import svang_pkg::*;

  localparam int CB   = COORD_BITS;
  localparam int PW   = 2 * CB;
  localparam int NW   = 2 * CB + 1;
  localparam int DW   = 2 * CB + 2;
  localparam int P    = (CB > 16) ? 2 * CB - 32 : 0;
  localparam int MW   = DW - P;
  localparam int SQW  = 2 * MW + 2;
  localparam int RW   = MW + 1;
  localparam int XW   = MW + 4;
  localparam int OW   = NW + CB;
  localparam int SW   = OW + 2;
  localparam int EW   = XW + 1;
  localparam int NAW  = EW + P;
  localparam int TW   = (NAW > NT_W) ? NAW + 1 : NT_W + 1;
  localparam int BW   = ((NAW + CB_W > DW + 15) ? NAW + CB_W : DW + 15) + 1;

  logic en;

  // configuration
  logic [NT_W-1:0] null_thr_r;
  logic [CB_W-1:0] cos_band_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      null_thr_r <= '0;
      cos_band_r <= '0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_NULL_THRESHOLD: null_thr_r <= cfg_ch.data;
        REG_COS_BAND:       cos_band_r <= cfg_ch.data[CB_W-1:0];
        default: ;
      endcase
    end
  end

  // stage A: products
  logic                 a_vld_r;
  logic [1:0]           a_op_r;
  logic signed [PW-1:0] a_pr_r [9];
  logic signed [CB-1:0] a_o_r [3];

  // stage B: cross and dot
  logic                 b_vld_r;
  logic [1:0]           b_op_r;
  logic signed [NW-1:0] b_n_r [3];
  logic signed [DW-1:0] b_d_r;
  logic signed [CB-1:0] b_o_r [3];

  // stage C: squares and orientation products
  logic                  c_vld_r;
  logic [1:0]            c_op_r;
  logic [SQW-1:0]        c_sq_r [3];
  logic signed [OW-1:0]  c_no_r [3];
  logic [DW-1:0]         c_dm_r;
  logic                  c_dpos_r;

  // stage D: sums
  ctl_t           d_ctl_r;
  logic [SQW-1:0] d_sq_r;
  logic [DW-1:0]  d_dm_r;

  logic [NW-1:0]        b_nmag [3];
  logic [MW-1:0]        b_m [3];
  logic [DW-1:0]        b_dm;
  logic signed [SW-1:0] c_dot;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      b_nmag[i] = b_n_r[i][NW-1] ? NW'(-b_n_r[i]) : NW'(b_n_r[i]);
      b_m[i]    = MW'(b_nmag[i] >> P);
    end
    b_dm  = b_d_r[DW-1] ? DW'(-b_d_r) : DW'(b_d_r);
    c_dot = SW'(c_no_r[0]) + SW'(c_no_r[1]) + SW'(c_no_r[2]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
      d_ctl_r <= '0;
    end else if (en) begin
      a_vld_r <= in_ch.valid;
      b_vld_r <= a_vld_r;
      c_vld_r <= b_vld_r;
      d_ctl_r.vld     <= c_vld_r;
      d_ctl_r.opcode  <= c_op_r;
      d_ctl_r.d_pos   <= c_dpos_r;
      d_ctl_r.dot_neg <= c_dot[SW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_op_r    <= in_ch.opcode;
      a_pr_r[0] <= PW'(in_ch.a_y) * PW'(in_ch.b_z);
      a_pr_r[1] <= PW'(in_ch.a_z) * PW'(in_ch.b_y);
      a_pr_r[2] <= PW'(in_ch.a_z) * PW'(in_ch.b_x);
      a_pr_r[3] <= PW'(in_ch.a_x) * PW'(in_ch.b_z);
      a_pr_r[4] <= PW'(in_ch.a_x) * PW'(in_ch.b_y);
      a_pr_r[5] <= PW'(in_ch.a_y) * PW'(in_ch.b_x);
      a_pr_r[6] <= PW'(in_ch.a_x) * PW'(in_ch.b_x);
      a_pr_r[7] <= PW'(in_ch.a_y) * PW'(in_ch.b_y);
      a_pr_r[8] <= PW'(in_ch.a_z) * PW'(in_ch.b_z);
      a_o_r[0]  <= in_ch.orient_x;
      a_o_r[1]  <= in_ch.orient_y;
      a_o_r[2]  <= in_ch.orient_z;

      b_op_r   <= a_op_r;
      b_n_r[0] <= NW'(a_pr_r[0]) - NW'(a_pr_r[1]);
      b_n_r[1] <= NW'(a_pr_r[2]) - NW'(a_pr_r[3]);
      b_n_r[2] <= NW'(a_pr_r[4]) - NW'(a_pr_r[5]);
      b_d_r    <= DW'(a_pr_r[6]) + DW'(a_pr_r[7]) + DW'(a_pr_r[8]);
      b_o_r    <= a_o_r;

      c_op_r   <= b_op_r;
      c_dm_r   <= b_dm;
      c_dpos_r <= !b_d_r[DW-1] && (b_d_r != '0);
      for (int i = 0; i < 3; i++) begin
        c_sq_r[i] <= SQW'(b_m[i]) * SQW'(b_m[i]);
        c_no_r[i] <= OW'(b_n_r[i]) * OW'(b_o_r[i]);
      end

      d_sq_r <= c_sq_r[0] + c_sq_r[1] + c_sq_r[2];
      d_dm_r <= c_dm_r;
    end
  end

  // square root chain
  ctl_t           sq_ctl  [RW+1];
  logic [SQW-1:0] sq_rem  [RW+1];
  logic [RW-1:0]  sq_root [RW+1];
  logic [DW-1:0]  sq_dm   [RW+1];

  assign sq_ctl[0]  = d_ctl_r;
  assign sq_rem[0]  = d_sq_r;
  assign sq_root[0] = '0;
  assign sq_dm[0]   = d_dm_r;

  for (genvar j = 0; j < RW; j++) begin : g_sqrt
    svang_sqrt_cell #(.K(RW - 1 - j), .SQW(SQW), .RW(RW), .DW(DW)) u_cell (
      .clk, .rst_n, .en,
      .ctl_i(sq_ctl[j]), .rem_i(sq_rem[j]), .root_i(sq_root[j]), .dm_i(sq_dm[j]),
      .ctl_o(sq_ctl[j+1]), .rem_o(sq_rem[j+1]), .root_o(sq_root[j+1]),
      .dm_o(sq_dm[j+1])
    );
  end

  // CORDIC chain
  ctl_t                  co_ctl [CORDIC_STAGES+1];
  logic signed [XW-1:0]  co_x   [CORDIC_STAGES+1];
  logic signed [XW-1:0]  co_y   [CORDIC_STAGES+1];
  logic signed [Z_W-1:0] co_z   [CORDIC_STAGES+1];
  logic [DW-1:0]         co_dm  [CORDIC_STAGES+1];

  assign co_ctl[0] = sq_ctl[RW];
  assign co_x[0]   = $signed(XW'(sq_dm[RW] >> P));
  assign co_y[0]   = $signed(XW'(sq_root[RW]));
  assign co_z[0]   = '0;
  assign co_dm[0]  = sq_dm[RW];

  for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_cordic
    svang_cordic_cell #(.I(s), .XW(XW), .DW(DW)) u_cell (
      .clk, .rst_n, .en,
      .ctl_i(co_ctl[s]), .x_i(co_x[s]), .y_i(co_y[s]), .z_i(co_z[s]), .dm_i(co_dm[s]),
      .ctl_o(co_ctl[s+1]), .x_o(co_x[s+1]), .y_o(co_y[s+1]), .z_o(co_z[s+1]),
      .dm_o(co_dm[s+1])
    );
  end

  // stage E1: gain correction and angle rounding
  ctl_t                    e1_ctl_r;
  logic [EW-1:0]           e1_est_r;
  logic signed [ANG_W-1:0] e1_q_r;
  logic [DW-1:0]           e1_dm_r;

  logic signed [Z_W-1:0]   zc;
  logic signed [Z_W-1:0]   zr;
  logic signed [ANG_W-1:0] q_nxt;
  logic [XW-2:0]           xu;
  logic [EW-1:0]           est_nxt;

  always_comb begin
    zc = co_z[CORDIC_STAGES];
    if (zc < 0) begin
      zc = '0;
    end else if (zc > HALF_PI_Q29) begin
      zc = HALF_PI_Q29;
    end
    zr    = (zc + 32'sd32768) >>> 16;
    q_nxt = (zr > Z_W'(HALF_PI_Q13)) ? HALF_PI_Q13 : ANG_W'(zr);
    xu    = co_x[CORDIC_STAGES][XW-2:0];
    est_nxt = EW'(xu >> 15) * EW'(GAIN_Q15)
            + ((EW'(xu[14:0]) * EW'(GAIN_Q15)) >> 15);
  end

  // stage E2: null test and band product
  ctl_t                    e2_ctl_r;
  logic                    e2_null_r;
  logic [BW-1:0]           e2_bp_r;
  logic signed [ANG_W-1:0] e2_q_r;
  logic [DW-1:0]           e2_dm_r;
  logic [NAW-1:0]          norm_ab;

  assign norm_ab = NAW'(e1_est_r) << P;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e1_ctl_r <= '0;
      e2_ctl_r <= '0;
    end else if (en) begin
      e1_ctl_r <= co_ctl[CORDIC_STAGES];
      e2_ctl_r <= e1_ctl_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e1_est_r  <= est_nxt;
      e1_q_r    <= q_nxt;
      e1_dm_r   <= co_dm[CORDIC_STAGES];
      e2_null_r <= TW'(norm_ab) <= TW'(null_thr_r);
      e2_bp_r   <= BW'(cos_band_r) * BW'(norm_ab);
      e2_q_r    <= e1_q_r;
      e2_dm_r   <= e1_dm_r;
    end
  end

  // stage E3: final angle into the output register
  logic                    band;
  logic                    neg;
  logic signed [ANG_W-1:0] mag;
  logic signed [ANG_W-1:0] ang_nxt;
  logic                    ok_nxt;

  always_comb begin
    band = (e2_dm_r == '0) || ((BW'(e2_dm_r) << 15) < e2_bp_r);
    neg  = (e2_ctl_r.opcode != OP_SHORT) && e2_ctl_r.dot_neg;
    if (band) begin
      mag = HALF_PI_Q13;
    end else begin
      mag = e2_ctl_r.d_pos ? e2_q_r : PI_Q13 - e2_q_r;
    end
    ang_nxt = neg ? -mag : mag;
    if (e2_ctl_r.opcode == OP_POSITIVE && ang_nxt[ANG_W-1]) begin
      ang_nxt = ang_nxt + TWO_PI_Q13;
    end
    ok_nxt = (e2_ctl_r.opcode != OP_UNDEF) && !e2_null_r;
    if (!ok_nxt) begin
      ang_nxt = '0;
    end
  end

  logic                    out_vld_r;
  logic signed [ANG_W-1:0] out_ang_r;
  logic                    out_ok_r;

  assign en          = !out_vld_r || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= e2_ctl_r.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_ang_r <= ang_nxt;
      out_ok_r  <= ok_nxt;
    end
  end

  assign out_ch.valid     = out_vld_r;
  assign out_ch.angle     = out_ang_r;
  assign out_ch.valid_res = out_ok_r;
endmodule

// ----- design/svang_sqrt_cell.sv -----
// svang_sqrt_cell: one cell of the square root chain, settles root bit K.
// Depends on svang_pkg.
module svang_sqrt_cell #(
  parameter int K   = 0,
  parameter int SQW = 8,
  parameter int RW  = 4,
  parameter int DW  = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  svang_pkg::ctl_t            ctl_i,
  input  logic [SQW-1:0]             rem_i,
  input  logic [RW-1:0]              root_i,
  input  logic [DW-1:0]              dm_i,
  output svang_pkg::ctl_t            ctl_o,
  output logic [SQW-1:0]             rem_o,
  output logic [RW-1:0]              root_o,
  output logic [DW-1:0]              dm_o
);
  import svang_pkg::*;

  ctl_t           ctl_r;
  logic [SQW-1:0] rem_r, rem_nxt;
  logic [RW-1:0]  root_r, root_nxt;
  logic [DW-1:0]  dm_r;
  logic [SQW:0]   trial;
  logic           ge;

  always_comb begin
    trial    = ((SQW+1)'(root_i) << (K + 1)) | ((SQW+1)'(1) << (2 * K));
    ge       = {1'b0, rem_i} >= trial;
    rem_nxt  = ge ? rem_i - trial[SQW-1:0] : rem_i;
    root_nxt = root_i | (RW'(ge) << K);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      dm_r   <= dm_i;
    end
  end

  assign ctl_o  = ctl_r;
  assign rem_o  = rem_r;
  assign root_o = root_r;
  assign dm_o   = dm_r;
endmodule

// ----- design/svang_cordic_cell.sv -----
// svang_cordic_cell: one vectoring micro-rotation of the CORDIC chain.
// Depends on svang_pkg for the arctangent table.
module svang_cordic_cell #(
  parameter int I  = 0,
  parameter int XW = 8,
  parameter int DW = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  svang_pkg::ctl_t                ctl_i,
  input  logic signed [XW-1:0]           x_i,
  input  logic signed [XW-1:0]           y_i,
  input  logic signed [svang_pkg::Z_W-1:0] z_i,
  input  logic [DW-1:0]                  dm_i,
  output svang_pkg::ctl_t                ctl_o,
  output logic signed [XW-1:0]           x_o,
  output logic signed [XW-1:0]           y_o,
  output logic signed [svang_pkg::Z_W-1:0] z_o,
  output logic [DW-1:0]                  dm_o
);
  import svang_pkg::*;

  ctl_t                  ctl_r;
  logic signed [XW-1:0]  x_r, y_r, x_nxt, y_nxt, xs, ys;
  logic signed [Z_W-1:0] z_r, z_nxt, step;
  logic [DW-1:0]         dm_r;

  always_comb begin
    xs   = x_i >>> I;
    ys   = y_i >>> I;
    step = $signed(atan_q29(I));
    if (!y_i[XW-1]) begin
      x_nxt = x_i + ys;
      y_nxt = y_i - xs;
      z_nxt = z_i + step;
    end else begin
      x_nxt = x_i - ys;
      y_nxt = y_i + xs;
      z_nxt = z_i - step;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r  <= x_nxt;
      y_r  <= y_nxt;
      z_r  <= z_nxt;
      dm_r <= dm_i;
    end
  end

  assign ctl_o = ctl_r;
  assign x_o   = x_r;
  assign y_o   = y_r;
  assign z_o   = z_r;
  assign dm_o  = dm_r;
endmodule

// ----- design/svang_chk.sv -----
// svang_chk: port-level checks on the signed vector angle block, bound to
// the top level. Depends on svang_pkg.
module svang_chk (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [svang_pkg::ANG_W-1:0] angle,
  input logic                              valid_res
);
  import svang_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(angle) && $stable(valid_res))
    else $error("result changed while stalled");

  a_null_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !valid_res |-> angle == '0)
    else $error("null result with nonzero angle");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && valid_res |-> angle >= -PI_Q13 && angle <= TWO_PI_Q13)
    else $error("angle out of range");

  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output backpressure");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");
endmodule

bind signed_vector_angle svang_chk u_svang_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .angle     (out_ch.angle),
  .valid_res (out_ch.valid_res)
);

// ----- tb/testbench.sv -----
// Testbench for signed_vector_angle: drives vector pairs through the block,
// predicts each angle in SystemVerilog unless a directed row gives it, and
// checks every result transfer. Depends on svang_pkg, svang_if and the RTL.
`timescale 1ns / 100ps

module testbench;
  import svang_pkg::*;

  localparam int PIPE_WAIT = 70;
  localparam int IDLE_LIMIT = 5000;
  localparam int PHASE_ITEMS = 256;

  typedef struct {
    logic [1:0] opcode;
    logic signed [15:0] ax, ay, az, bx, by, bz, ox, oy, oz;
  } vec_pair_t;

  typedef struct {
    logic signed [ANG_W-1:0] angle;
    logic valid_res;
  } angle_res_t;

  typedef struct {
    vec_pair_t v;
    bit typed;
    angle_res_t res;
  } stim_row_t;

  localparam longint ATAN_Q29 [16] = '{
    421657428, 248918915, 131521918, 66762579, 33510843, 16771758,
    8387925, 4194219, 2097141, 1048575, 524288, 262144,
    131072, 65536, 32768, 16384};

  logic clk = 0;
  logic rst_n = 0;

  svang_in_if  in_ch();
  svang_out_if out_ch();
  svang_cfg_if cfg_ch();

  signed_vector_angle dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  always #5 clk = ~clk;

  logic [NT_W-1:0] null_thr = '0;
  logic [CB_W-1:0] band_q15 = '0;
  angle_res_t pending_angles[$];
  int errs = 0;
  int idle_cycles = 0;
  int burst_left = 0;

  function automatic angle_res_t predict_angle(vec_pair_t v, logic [NT_W-1:0] thr,
                                               logic [CB_W-1:0] cb);
    angle_res_t r;
    longint ax, ay, az, bx, by, bz, n0, n1, n2, d, dm, x, y, z, xs, ys, est, q, mag, ang;
    longint ndo;
    logic [63:0] sq, m0, m1, m2, rem, bitv, nn, xu;
    bit band, neg;
    r.angle = '0;
    r.valid_res = 1'b0;
    if (v.opcode == OP_UNDEF) return r;
    ax = v.ax; ay = v.ay; az = v.az;
    bx = v.bx; by = v.by; bz = v.bz;
    n0 = ay * bz - az * by;
    n1 = az * bx - ax * bz;
    n2 = ax * by - ay * bx;
    d = ax * bx + ay * by + az * bz;
    dm = d < 0 ? -d : d;
    m0 = n0 < 0 ? -n0 : n0;
    m1 = n1 < 0 ? -n1 : n1;
    m2 = n2 < 0 ? -n2 : n2;
    sq = m0 * m0 + m1 * m1 + m2 * m2;
    rem = sq;
    nn = 0;
    bitv = 64'h4000_0000_0000_0000;
    while (bitv > rem) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= nn + bitv) begin
        rem = rem - (nn + bitv);
        nn = (nn >> 1) + bitv;
      end else begin
        nn = nn >> 1;
      end
      bitv = bitv >> 2;
    end
    x = dm;
    y = longint'(nn);
    z = 0;
    for (int i = 0; i < 16; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys; y = y - xs; z = z + ATAN_Q29[i];
      end else begin
        x = x - ys; y = y + xs; z = z - ATAN_Q29[i];
      end
    end
    if (z < 0) z = 0;
    if (z > longint'(HALF_PI_Q29)) z = HALF_PI_Q29;
    xu = x;
    est = longint'((xu >> 15) * 19898 + (((xu & 64'h7FFF) * 19898) >> 15));
    if (est <= longint'({31'd0, thr})) return r;
    band = (dm == 0) || ((dm <<< 15) < longint'({49'd0, cb}) * est);
    ndo = n0 * longint'(v.ox) + n1 * longint'(v.oy) + n2 * longint'(v.oz);
    neg = (v.opcode != OP_SHORT) && (ndo < 0);
    if (band) begin
      mag = 12868;
    end else begin
      q = (z + 32768) >>> 16;
      if (q > 12868) q = 12868;
      mag = d > 0 ? q : 25736 - q;
    end
    ang = neg ? -mag : mag;
    if (v.opcode == OP_POSITIVE && ang < 0) ang = ang + 51472;
    r.angle = ang[ANG_W-1:0];
    r.valid_res = 1'b1;
    return r;
  endfunction

  function automatic logic signed [15:0] pick_coord();
    int sel;
    sel = $urandom_range(0, 4);
    case (sel)
      0: return -16'sd32768;
      1: return -16'sd1;
      2: return 16'sd0;
      3: return 16'sd1;
      default: return 16'sd32767;
    endcase
  endfunction

  function automatic logic signed [15:0] rnd_in(int lim);
    return 16'($signed($urandom_range(0, 2 * lim)) - lim);
  endfunction

  function automatic vec_pair_t random_pair();
    vec_pair_t v;
    int kind, lim, s, opsel;
    logic signed [15:0] cx, cy, cz;
    kind = $urandom_range(0, 9);
    {v.ax, v.ay, v.az} = 48'({$urandom(), $urandom()});
    {v.bx, v.by, v.bz} = 48'({$urandom(), $urandom()});
    {v.ox, v.oy, v.oz} = 48'({$urandom(), $urandom()});
    case (kind)
      3, 4: begin
        lim = $urandom_range(1, 256);
        v.ax = rnd_in(lim); v.ay = rnd_in(lim); v.az = rnd_in(lim);
        v.bx = rnd_in(lim); v.by = rnd_in(lim); v.bz = rnd_in(lim);
      end
      5: begin
        s = $urandom_range(0, 3);
        s = s < 2 ? s - 2 : s - 1;
        v.ax = rnd_in(8000); v.ay = rnd_in(8000); v.az = rnd_in(8000);
        v.bx = 16'(s * v.ax + rnd_in(3));
        v.by = 16'(s * v.ay + rnd_in(3));
        v.bz = 16'(s * v.az + rnd_in(3));
      end
      6: begin
        v.ax = rnd_in(120); v.ay = rnd_in(120); v.az = rnd_in(120);
        cx = rnd_in(120); cy = rnd_in(120); cz = rnd_in(120);
        v.bx = 16'(v.ay * cz - v.az * cy + rnd_in(2));
        v.by = 16'(v.az * cx - v.ax * cz + rnd_in(2));
        v.bz = 16'(v.ax * cy - v.ay * cx + rnd_in(2));
      end
      7: begin
        if ($urandom_range(0, 1)) {v.ax, v.ay, v.az} = '0;
        else {v.bx, v.by, v.bz} = '0;
      end
      8: begin
        if ($urandom_range(0, 1)) {v.ox, v.oy, v.oz} = '0;
        else begin
          v.ox = rnd_in(2); v.oy = rnd_in(2); v.oz = rnd_in(2);
        end
      end
      9: begin
        v.ax = pick_coord(); v.ay = pick_coord(); v.az = pick_coord();
        v.bx = pick_coord(); v.by = pick_coord(); v.bz = pick_coord();
        v.ox = pick_coord(); v.oy = pick_coord(); v.oz = pick_coord();
      end
      default: ;
    endcase
    opsel = $urandom_range(0, 15);
    v.opcode = opsel < 14 ? 2'(opsel % 3) : OP_UNDEF;
    return v;
  endfunction

  task automatic send_pair(vec_pair_t v, bit typed, angle_res_t res);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_ch.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_ch.opcode = v.opcode;
    in_ch.a_x = v.ax; in_ch.a_y = v.ay; in_ch.a_z = v.az;
    in_ch.b_x = v.bx; in_ch.b_y = v.by; in_ch.b_z = v.bz;
    in_ch.orient_x = v.ox; in_ch.orient_y = v.oy; in_ch.orient_z = v.oz;
    in_ch.valid = 1'b1;
    forever begin
      @(posedge clk);
      if (in_ch.ready) break;
    end
    pending_angles.push_back(typed ? res : predict_angle(v, null_thr, band_q15));
  endtask

  task automatic drain_pipe();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pending_angles.size() != 0) @(posedge clk);
    repeat (PIPE_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [NT_W-1:0] val);
    @(negedge clk);
    cfg_ch.index = idx;
    cfg_ch.data = val;
    cfg_ch.valid = 1'b1;
    forever begin
      @(posedge clk);
      if (cfg_ch.ready) break;
    end
    if (idx == REG_NULL_THRESHOLD) null_thr = val;
    else band_q15 = val[CB_W-1:0];
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // receiver: drive ready in stall modes that are chosen anew at random
  int stall_mode = 0;
  int stall_cnt = 0;
  always @(negedge clk) begin
    if (stall_cnt % 64 == 0) stall_mode = $urandom_range(0, 3);
    stall_cnt++;
    case (stall_mode)
      0: out_ch.ready = 1'b1;
      1: out_ch.ready = $urandom_range(0, 1);
      2: out_ch.ready = (stall_cnt % 4 == 0);
      default: out_ch.ready = $urandom_range(0, 9) != 0;
    endcase
  end

  always @(posedge clk) begin
    angle_res_t want;
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
          || (cfg_ch.valid && cfg_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (pending_angles.size() == 0) begin
          $error("result transfer with nothing expected: angle %0d valid_res %0d",
                 out_ch.angle, out_ch.valid_res);
          errs++;
        end else begin
          want = pending_angles.pop_front();
          if (out_ch.angle !== want.angle) begin
            $error("angle: expected %0d, got %0d", want.angle, out_ch.angle);
            errs++;
          end
          if (out_ch.valid_res !== want.valid_res) begin
            $error("valid_res: expected %0d, got %0d", want.valid_res, out_ch.valid_res);
            errs++;
          end
        end
      end
    end
  end

  stim_row_t dir_rows[$];
  logic [NT_W-1:0] thr_set[6] = '{33'd0, 33'd1000000, 33'h1_FFFF_FFFF, 33'd500, 33'd0, 33'd0};
  logic [CB_W-1:0] cb_set[6] = '{15'd0, 15'd16384, 15'd32767, 15'd0, 15'd32767, 15'd0};

  initial begin
    in_ch.valid = 1'b0;
    in_ch.opcode = '0;
    {in_ch.a_x, in_ch.a_y, in_ch.a_z, in_ch.b_x, in_ch.b_y, in_ch.b_z} = '0;
    {in_ch.orient_x, in_ch.orient_y, in_ch.orient_z} = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    dir_rows = '{
      '{'{OP_SIGNED, 0, 0, 0, 0, 0, 0, 0, 0, 0}, 1, '{0, 0}},
      '{'{OP_UNDEF, 5, 6, 7, 1, 2, 3, 0, 0, 1}, 1, '{0, 0}},
      '{'{OP_UNDEF, 0, 0, 0, 0, 0, 0, 0, 0, 0}, 1, '{0, 0}},
      '{'{OP_SIGNED, 100, 0, 0, 0, 100, 0, 0, 0, 1}, 1, '{12868, 1}},
      '{'{OP_SIGNED, 100, 0, 0, 0, 100, 0, 0, 0, -1}, 1, '{-12868, 1}},
      '{'{OP_POSITIVE, 100, 0, 0, 0, 100, 0, 0, 0, -1}, 1, '{38604, 1}},
      '{'{OP_SHORT, 100, 0, 0, 0, 100, 0, 0, 0, -1}, 1, '{12868, 1}},
      '{'{OP_POSITIVE, -32768, 0, 0, 0, -32768, 0, 0, 0, -32768}, 1, '{38604, 1}},
      '{'{OP_POSITIVE, 0, 0, 0, 7, -9, 11, 1, 1, 1}, 1, '{0, 0}},
      '{'{OP_SIGNED, 1000, 2000, 3000, 1000, 2000, 3000, 0, 0, 1}, 0, '{0, 0}},
      '{'{OP_SIGNED, 100, 0, 0, -100, 0, 0, 0, 1, 0}, 0, '{0, 0}},
      '{'{OP_POSITIVE, 100, 0, 0, -100, 0, 0, 0, -1, 0}, 0, '{0, 0}},
      '{'{OP_SIGNED, 32767, 32767, 32767, -32768, -32768, -32768, 1, 0, 0}, 0, '{0, 0}},
      '{'{OP_SIGNED, 32767, -32768, 1, -1, 32767, -32768, 32767, -32768, -1}, 0, '{0, 0}},
      '{'{OP_POSITIVE, 32767, -32768, 1, -1, 32767, -32768, -32768, 32767, 1}, 0, '{0, 0}},
      '{'{OP_SHORT, -32768, -32768, -32768, 32767, -32768, 32767, -1, -1, -1}, 0, '{0, 0}},
      '{'{OP_SIGNED, 3, 4, 0, -4, 3, 1, 0, 0, -5}, 0, '{0, 0}},
      '{'{OP_POSITIVE, 3, 4, 0, -5, -3, 1, 0, 0, -5}, 0, '{0, 0}},
      '{'{OP_SIGNED, 5, 1, 0, 1, 5, 0, 0, 0, 0}, 0, '{0, 0}},
      '{'{OP_SHORT, 1, 0, 0, 1, 1, 0, 0, 0, -1}, 0, '{0, 0}},
      '{'{OP_POSITIVE, 32767, 0, 0, 32767, 1, 0, 0, 0, -1}, 0, '{0, 0}}
    };
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    foreach (dir_rows[k]) send_pair(dir_rows[k].v, dir_rows[k].typed, dir_rows[k].res);
    drain_pipe();
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 5) begin
        thr_set[ph] = {$urandom(), 1'b0} & 33'h0_00FF_FFFF;
        cb_set[ph] = CB_W'($urandom());
      end
      write_reg(REG_NULL_THRESHOLD, thr_set[ph]);
      write_reg(REG_COS_BAND, {18'd0, cb_set[ph]});
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (ph == 3 && k == PHASE_ITEMS / 2) begin
          @(negedge clk);
          in_ch.valid = 1'b0;
          burst_left = 0;
          while (pending_angles.size() != 0) @(posedge clk);
        end
        send_pair(random_pair(), 1'b0, '{0, 0});
      end
      drain_pipe();
    end
    if (errs == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
